// ===== src/rv32i_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32i_pkg
// shared constants, opcodes and types for the rv32i instruction executor
// ----------------------------------------------------------------------------
`default_nettype none
package rv32i_pkg;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
    localparam logic [31:0] STOP_RESET = 32'd4096;

    localparam logic CFG_START_PC = 1'b0;
    localparam logic CFG_STOP_PC  = 1'b1;

    typedef enum logic [1:0] {
        LK_LB  = 2'd0,
        LK_LW  = 2'd1,
        LK_LBU = 2'd2,
        LK_LW3 = 2'd3
    } load_kind_t;

    // register writeback from the execute stage
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } wb_t;
endpackage
`default_nettype wire

// ===== src/rv32i_regfile.sv =====
// ----------------------------------------------------------------------------
// rv32i_regfile
// register file, x0 and indexes at or above REG_COUNT read zero
// ----------------------------------------------------------------------------
`default_nettype none
module rv32i_regfile (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rv32i_pkg::wb_t  wb,
    input  wire logic [4:0]      ra1,
    input  wire logic [4:0]      ra2,
    output logic [31:0]          rd1,
    output logic [31:0]          rd2,
    output logic [31:0]          rd_a7,
    output logic [31:0]          rd_a0
);
    import rv32i_pkg::*;

    logic [31:0] regs_reg [REG_COUNT];

    function automatic logic [31:0] rd(input logic [31:0] r [REG_COUNT], input logic [4:0] a);
        logic [31:0] v;
        v = '0;
        if (a != 5'd0 && 32'(a) < REG_COUNT) v = r[a[REG_AW-1:0]];
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) regs_reg[i] <= '0;
        end else if (wb.en && wb.addr != 5'd0 && 32'(wb.addr) < REG_COUNT) begin
            regs_reg[wb.addr[REG_AW-1:0]] <= wb.data;
        end
    end

    assign rd1   = rd(regs_reg, ra1);
    assign rd2   = rd(regs_reg, ra2);
    assign rd_a7 = rd(regs_reg, 5'd17);
    assign rd_a0 = rd(regs_reg, 5'd10);
endmodule
`default_nettype wire

// ===== src/rv32i_instruction_executor_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_executor_unit
// rv32i execute core with load return and environment call report
// ----------------------------------------------------------------------------
// Each input transaction either executes one instruction word or returns data
// for the pending load. Decode, register read, alu and next pc are one pass of
// logic from the register file into the result register, so one transaction
// is accepted per clock and is registered into the result register; the result
// register is refilled in the same cycle it is taken, so s_ready is low only
// while a result waits and m_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32i_instruction_executor_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    // input transactions
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [31:0] s_instr,
    input  wire logic [31:0] s_load_data,
    // result transactions
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_next_pc,
    output logic             m_mem_read,
    output logic             m_mem_write,
    output logic [31:0]      m_mem_addr,
    output logic [31:0]      m_mem_wdata,
    output logic             m_mem_size,
    output logic             m_env_call,
    output logic [31:0]      m_env_code,
    output logic [31:0]      m_env_arg,
    output logic             m_bad_opcode,
    output logic             m_halted
);
    import rv32i_pkg::*;

    logic [31:0] pc_reg, stop_reg;
    logic        pend_reg;
    logic [4:0]  ldst_reg;
    load_kind_t  lkind_reg;
    logic        valid_reg;

    logic [31:0] a, b, a7v, a0v;
    wb_t         wb;
    logic        acc;

    // instruction fields
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] iv, sv, bv, jv, nxt, sum_i, pc4;
    logic        take;

    assign op  = s_instr[6:0];
    assign rd  = s_instr[11:7];
    assign f3  = s_instr[14:12];
    assign rs1 = s_instr[19:15];
    assign rs2 = s_instr[24:20];
    assign f7  = s_instr[31:25];
    assign iv  = {{20{s_instr[31]}}, s_instr[31:20]};
    assign sv  = {{20{s_instr[31]}}, s_instr[31:25], s_instr[11:7]};
    assign bv  = {{19{s_instr[31]}}, s_instr[31], s_instr[7], s_instr[30:25],
                  s_instr[11:8], 1'b0};
    assign jv  = {{11{s_instr[31]}}, s_instr[31], s_instr[19:12], s_instr[20],
                  s_instr[30:21], 1'b0};
    assign sum_i = a + iv;
    assign pc4   = pc_reg + 32'd4;

    rv32i_regfile u_rf (
        .aclk(aclk), .aresetn(aresetn), .wb(wb), .ra1(rs1), .ra2(rs2),
        .rd1(a), .rd2(b), .rd_a7(a7v), .rd_a0(a0v)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = !valid_reg || m_ready;
    assign acc       = s_valid && s_ready;
    assign m_valid   = valid_reg;

    // result next values
    logic [31:0] npc_next, addr_next, wdata_next;
    logic        rdq_next, wrq_next, size_next, ecall_next, bad_next;
    logic        lstart;
    load_kind_t  lk_new;

    always_comb begin
        wb        = '0;
        nxt       = pc4;
        rdq_next  = 1'b0;
        wrq_next  = 1'b0;
        size_next = 1'b0;
        addr_next = '0;
        wdata_next= '0;
        ecall_next= 1'b0;
        bad_next  = 1'b0;
        lstart    = 1'b0;
        lk_new    = LK_LB;
        take      = 1'b0;
        if (s_action) begin
            // load return
            nxt = pc_reg;
            if (pend_reg) begin
                wb.en   = 1'b1;
                wb.addr = ldst_reg;
                case (lkind_reg)
                    LK_LB:   wb.data = {{24{s_load_data[7]}}, s_load_data[7:0]};
                    LK_LBU:  wb.data = {24'd0, s_load_data[7:0]};
                    default: wb.data = s_load_data;
                endcase
            end
        end else begin
            wb.addr = rd;
            unique case (op)
                OP_LOAD: begin
                    if (f3 == 3'd0 || f3 == 3'd2 || f3 == 3'd4) begin
                        lstart    = 1'b1;
                        lk_new    = (f3 == 3'd0) ? LK_LB : (f3 == 3'd2) ? LK_LW : LK_LBU;
                        rdq_next  = 1'b1;
                        addr_next = sum_i;
                        size_next = (f3 == 3'd2);
                    end
                end
                OP_IMM: begin
                    wb.en = 1'b1;
                    case (f3)
                        3'd0: wb.data = sum_i;
                        3'd7: wb.data = a & iv;
                        3'd6: wb.data = a | iv;
                        3'd1: begin
                            wb.en   = (f7 == 7'h00);
                            wb.data = a << rs2;
                        end
                        3'd5: begin
                            wb.en   = (f7 == 7'h00) || (f7 == 7'h20);
                            wb.data = f7[5] ? 32'($signed(a) >>> rs2) : (a >> rs2);
                        end
                        default: wb.en = 1'b0;
                    endcase
                end
                OP_REG: begin
                    wb.en = 1'b1;
                    if (f7 == 7'h20) begin
                        wb.en   = (f3 == 3'd0);
                        wb.data = a - b;
                    end else if (f7 == 7'h00) begin
                        case (f3)
                            3'd0: wb.data = a + b;
                            3'd2: wb.data = {31'd0, $signed(a) < $signed(b)};
                            3'd3: wb.data = {31'd0, a < b};
                            3'd4: wb.data = a ^ b;
                            3'd6: wb.data = a | b;
                            3'd7: wb.data = a & b;
                            default: wb.en = 1'b0;
                        endcase
                    end else begin
                        wb.en = 1'b0;
                    end
                end
                OP_STORE: begin
                    if (f3 == 3'd0 || f3 == 3'd2) begin
                        wrq_next   = 1'b1;
                        addr_next  = a + sv;
                        wdata_next = b;
                        size_next  = (f3 == 3'd2);
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        3'd0: take = (a == b);
                        3'd1: take = (a != b);
                        3'd4: take = $signed(a) < $signed(b);
                        3'd5: take = $signed(a) >= $signed(b);
                        3'd6: take = a < b;
                        3'd7: take = a >= b;
                        default: take = 1'b0;
                    endcase
                    if (take) nxt = pc_reg + bv;
                end
                OP_LUI: begin
                    wb.en   = 1'b1;
                    wb.data = {s_instr[31:12], 12'd0};
                end
                OP_AUIPC: begin
                    wb.en   = 1'b1;
                    wb.data = pc_reg + {s_instr[31:12], 12'd0};
                end
                OP_JAL: begin
                    wb.en   = 1'b1;
                    wb.data = pc4;
                    nxt     = pc_reg + jv;
                end
                OP_JALR: begin
                    if (f3 == 3'd0) begin
                        wb.en   = 1'b1;
                        wb.data = pc4;
                        nxt     = {sum_i[31:1], 1'b0};
                    end
                end
                OP_SYSTEM: begin
                    ecall_next = (s_instr == ECALL_WORD);
                end
                default: bad_next = 1'b1;
            endcase
        end
        wb.en    = wb.en && acc;
        npc_next = nxt;
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= '0;
            stop_reg  <= STOP_RESET;
            pend_reg  <= 1'b0;
            ldst_reg  <= '0;
            lkind_reg <= LK_LB;
        end else begin
            if (acc) begin
                pc_reg   <= npc_next;
                pend_reg <= !s_action && lstart;
                if (!s_action && lstart) begin
                    ldst_reg  <= rd;
                    lkind_reg <= lk_new;
                end
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_START_PC) pc_reg <= cfg_data;
                else stop_reg <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (s_ready) valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            m_next_pc    <= npc_next;
            m_mem_read   <= rdq_next;
            m_mem_write  <= wrq_next;
            m_mem_addr   <= addr_next;
            m_mem_wdata  <= wdata_next;
            m_mem_size   <= size_next;
            m_env_call   <= ecall_next;
            m_env_code   <= ecall_next ? a7v : 32'd0;
            m_env_arg    <= ecall_next ? a0v : 32'd0;
            m_bad_opcode <= bad_next;
            m_halted     <= (npc_next >= stop_reg);
        end
    end
endmodule
`default_nettype wire

// ===== src/rv32i_checker.sv =====
// ----------------------------------------------------------------------------
// rv32i_checker
// port-level checks on the executor's result channel
// ----------------------------------------------------------------------------
`default_nettype none
module rv32i_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_next_pc,
    input wire logic        m_mem_read,
    input wire logic        m_mem_write,
    input wire logic        m_env_call,
    input wire logic [31:0] m_env_code
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc)) else $error("result dropped");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_mem_read && m_mem_write)) else $error("read and write");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_env_call |-> m_env_code == 32'd0) else $error("env code");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid) else $error("result missing");
endmodule

bind rv32i_instruction_executor_unit rv32i_checker u_chk (.*);
`default_nettype wire
